// File: sv/pss_pkg.sv
package pss_pkg;

  localparam int unsigned IdxW  = 6;
  localparam int unsigned WordW = 31;

  // configuration register indexes
  localparam logic REG_POOL_SIZE  = 1'b0;
  localparam logic REG_DRAW_COUNT = 1'b1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_WORD  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic            accepted;
    logic [IdxW-1:0] position;
    logic [IdxW-1:0] card;
    logic            last;
    logic            done_res;
  } out_item_t;

endpackage

// File: sv/partial_shuffle_sampler.sv
// Items are handled one at a time: a drawn word passes through S_DIV, S_CHK and the swap
// states to S_FIN, a rejected word through S_DIV and S_CHK to S_FIN, and a start item or
// an ignored word straight to S_FIN. No new input transfer is taken until S_FIN has
// handed the result on. Restoring divider: one quotient bit per cycle, 31 steps; swap:
// S_RDA, S_RDB, S_WRA and S_WRB over the permutation store.
// Reset: pool_size 52, draw_count 0, draw position 0, store reads as identity through
// per-entry valid bits, so no clearing pass is needed.
module partial_shuffle_sampler import pss_pkg::*; #(
  parameter int unsigned DECK_SIZE  = 52,
  parameter int unsigned RANDOM_MAX = 2147483647
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [IdxW-1:0] cfg_data_i
);

  localparam int unsigned AW      = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
  localparam int unsigned TabSize = 1 << IdxW;
  localparam int unsigned CntW    = $clog2(WordW);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_CHK, S_RDA, S_RDB, S_WRA, S_WRB, S_FIN
  } state_e;

  state_e            state_q;
  logic [IdxW-1:0]   pool_q, draw_q;
  logic [IdxW-1:0]   pos_q;
  logic [DECK_SIZE-1:0] vld_q;
  logic [WordW-1:0]  word_q, rem_q, quo_q, div_q;
  logic [CntW-1:0]   cnt_q;
  logic              acc_q;
  logic [IdxW-1:0]   rpos_q, bpos_q, card_q, da_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [5:0]        mem [DECK_SIZE];
  logic [5:0]        mem_rd_q;
  logic              rd_vld_q;
  logic [AW-1:0]     rd_idx_q;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wa;
  logic [5:0]        wd;
  logic [5:0]        rd_val;

  logic [WordW-1:0]  div_tab [TabSize];
  logic [IdxW:0]     n7, k7, m7;
  logic [IdxW-1:0]   m;
  logic [WordW:0]    trial, diff;
  logic              in_fire, out_free, done;

  // divisor table: RANDOM_MAX/(m+1), with the last slot taking RANDOM_MAX itself
  for (genvar g = 0; g < TabSize; g++) begin : g_div
    localparam int unsigned Dv = (g == 0) ? RANDOM_MAX : RANDOM_MAX / (g + 1);
    assign div_tab[g] = WordW'(Dv);
  end

  always_comb begin
    n7 = ({1'b0, pool_q} < (IdxW+1)'(DECK_SIZE)) ? {1'b0, pool_q} : (IdxW+1)'(DECK_SIZE);
    k7 = ({1'b0, draw_q} < n7) ? {1'b0, draw_q} : n7;
    m7 = n7 - (IdxW+1)'(1) - {1'b0, pos_q};
    m  = m7[IdxW-1:0];
    done = ({1'b0, pos_q} >= k7);
    trial = {rem_q, word_q[WordW-1]};
    diff  = trial - {1'b0, div_q};
    rd_val = rd_vld_q ? mem_rd_q : 6'(rd_idx_q);
    rd_addr = (state_q == S_RDB) ? bpos_q[AW-1:0] : rpos_q[AW-1:0];
    we = 1'b0;
    wa = rpos_q[AW-1:0];
    wd = rd_val;
    case (state_q)
      S_WRA: we = 1'b1;
      S_WRB: begin
        we = 1'b1;
        wa = bpos_q[AW-1:0];
        wd = da_q;
      end
      default: we = 1'b0;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    mem_rd_q <= mem[rd_addr];
    rd_vld_q <= vld_q[rd_addr];
    rd_idx_q <= rd_addr;
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_q      <= IdxW'(52);
      draw_q      <= '0;
      pos_q       <= '0;
      vld_q       <= '0;
      acc_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_POOL_SIZE) begin
          pool_q <= cfg_data_i;
        end else begin
          draw_q <= cfg_data_i;
        end
      end
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      if (we) begin
        vld_q[wa] <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            acc_q   <= 1'b0;
            rpos_q  <= pos_q;
            word_q  <= in_data_i.random_word;
            rem_q   <= '0;
            quo_q   <= '0;
            div_q   <= div_tab[m];
            cnt_q   <= CntW'(WordW - 1);
            if (in_data_i.kind == KIND_START) begin
              vld_q   <= '0;
              pos_q   <= '0;
              state_q <= S_FIN;
            end else if (!done) begin
              state_q <= S_DIV;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_DIV: begin
          // one restoring step: shift in the next word bit, subtract if it fits
          word_q <= {word_q[WordW-2:0], 1'b0};
          if (!diff[WordW]) begin
            rem_q <= diff[WordW-1:0];
            quo_q <= {quo_q[WordW-2:0], 1'b1};
          end else begin
            rem_q <= trial[WordW-1:0];
            quo_q <= {quo_q[WordW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          bpos_q <= rpos_q + quo_q[IdxW-1:0];
          if (quo_q[WordW-1:IdxW] == '0 && quo_q[IdxW-1:0] <= m) begin
            acc_q   <= 1'b1;
            state_q <= S_RDA;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: begin
          da_q    <= rd_val;
          state_q <= S_WRA;
        end
        S_WRA: begin
          card_q  <= rd_val;
          state_q <= S_WRB;
        end
        S_WRB: begin
          pos_q   <= rpos_q + IdxW'(1);
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_q.accepted    <= acc_q;
            out_q.position    <= acc_q ? rpos_q : '0;
            out_q.card        <= acc_q ? card_q : '0;
            out_q.last        <= acc_q && done;
            out_q.done_res    <= done;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.kind == KIND_START |=> vld_q == '0 && pos_q == '0)
    else $error("start did not clear store and position");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.accepted |->
      out_data_o.position == '0 && out_data_o.card == '0 && !out_data_o.last)
    else $error("non-draw result carries nonzero fields");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.done_res && out_data_o.accepted)
    else $error("last without done");

  a_card_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> {1'b0, out_data_o.card} < (IdxW+1)'(DECK_SIZE))
    else $error("drawn index outside store");

endmodule

// File: verif/tb_partial_shuffle_sampler.sv
module tb_partial_shuffle_sampler;
  import pss_pkg::*;

  localparam int unsigned DECK         = 52;
  localparam int unsigned WORD_MAX     = 32'h7FFF_FFFF;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 280;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_op_e;

  typedef struct {
    row_op_e         op;
    logic            reg_idx;
    logic [IdxW-1:0] reg_val;
    in_item_t        item;
    bit              typed;
    out_item_t       want;
  } script_row_t;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_item_t        in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic            cfg_index = REG_POOL_SIZE;
  logic [IdxW-1:0] cfg_data  = '0;

  // shadow of the block
  logic [IdxW-1:0] pool_reg;
  logic [IdxW-1:0] count_reg;
  logic [IdxW-1:0] deck_order [DECK];
  int unsigned     next_slot;

  out_item_t    pending_draws[$];
  script_row_t  script[$];
  int unsigned  mismatches = 0;
  int unsigned  live_items = 0;
  int unsigned  cycles     = 0;
  int unsigned  tx_idle_pct = 18;
  int unsigned  rx_idle_pct = 77;
  int unsigned  hold_req  = 0;
  int unsigned  hold_seen = 0;
  int unsigned  hold_left = 0;

  partial_shuffle_sampler #(
    .DECK_SIZE (DECK),
    .RANDOM_MAX(WORD_MAX)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        note_failure($sformatf("unexpected result acc=%0d pos=%0d card=%0d last=%0d done=%0d",
                               out_data.accepted, out_data.position, out_data.card,
                               out_data.last, out_data.done_res));
      end else begin
        want = pending_draws.pop_front();
        if (out_data.accepted !== want.accepted || out_data.position !== want.position ||
            out_data.card !== want.card || out_data.last !== want.last ||
            out_data.done_res !== want.done_res) begin
          note_failure($sformatf({"mismatch: expected acc=%0d pos=%0d card=%0d last=%0d ",
                                  "done=%0d, got acc=%0d pos=%0d card=%0d last=%0d done=%0d"},
                                 want.accepted, want.position, want.card, want.last,
                                 want.done_res, out_data.accepted, out_data.position,
                                 out_data.card, out_data.last, out_data.done_res));
        end
      end
    end
  end

  function automatic void restack();
    for (int j = 0; j < DECK; j++) deck_order[j] = IdxW'(j);
    next_slot = 0;
  endfunction

  function automatic int unsigned draw_goal();
    int unsigned n;
    n = (pool_reg < DECK) ? pool_reg : DECK;
    return (count_reg < n) ? count_reg : n;
  endfunction

  // one step of the partial shuffle; updates the shadow state
  function automatic out_item_t shuffle_draw(input in_item_t it);
    int unsigned n, k, m, divisor, r, a, b;
    logic [IdxW-1:0] tmp;
    out_item_t res;
    res = '0;
    n = (pool_reg < DECK) ? pool_reg : DECK;
    k = draw_goal();
    if (it.kind == KIND_START) begin
      restack();
      live_items++;
    end else if (next_slot < k) begin
      live_items++;
      m = n - 1 - next_slot;
      // last slot divides by the full range, so only the top word is rejected
      divisor = (m == 0) ? WORD_MAX : WORD_MAX / (m + 1);
      r = it.random_word / divisor;
      if (r <= m) begin
        a = next_slot;
        b = next_slot + r;
        tmp = deck_order[a];
        deck_order[a] = deck_order[b];
        deck_order[b] = tmp;
        res.accepted = 1'b1;
        res.position = a[IdxW-1:0];
        res.card     = deck_order[a];
        next_slot    = (a + 1) & 32'h3F;
        res.last     = (next_slot >= k);
      end
    end
    res.done_res = (next_slot >= k);
    return res;
  endfunction

  function automatic out_item_t outcome(input bit acc, input int pos, input int card,
                                        input bit last, input bit done);
    out_item_t o;
    o.accepted = acc;
    o.position = IdxW'(pos);
    o.card     = IdxW'(card);
    o.last     = last;
    o.done_res = done;
    return o;
  endfunction

  function automatic void add_item(input logic kind, input int unsigned word,
                                   input bit typed, input out_item_t want);
    script_row_t row;
    row.op               = ROW_ITEM;
    row.reg_idx          = REG_POOL_SIZE;
    row.reg_val          = '0;
    row.item.kind        = kind;
    row.item.random_word = WordW'(word);
    row.typed            = typed;
    row.want             = want;
    script.push_back(row);
  endfunction

  function automatic void add_cfg(input logic idx, input int unsigned val);
    script_row_t row;
    row.op      = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = IdxW'(val);
    row.item    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    script.push_back(row);
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return WordW'(WORD_MAX);
      2, 3:    return WordW'(WORD_MAX - $urandom_range(0, 63));
      default: return WordW'($urandom());
    endcase
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predicted = shuffle_draw(it);
    pending_draws.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [IdxW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_POOL_SIZE) pool_reg = val;
    else count_reg = val;
  endtask

  task automatic reconfigure();
    logic [IdxW-1:0] p, c;
    case ($urandom_range(19))
      0:             p = '0;
      1, 2:          p = IdxW'(52);
      3:             p = IdxW'(63);
      4, 5:          p = IdxW'(1);
      6, 7, 8, 9:    p = IdxW'($urandom_range(1, 52));
      default:       p = IdxW'($urandom_range(2, 10));
    endcase
    case ($urandom_range(19))
      0:             c = '0;
      1:             c = IdxW'(63);
      2, 3:          c = IdxW'(52);
      4, 5:          c = p;
      6, 7, 8, 9:    c = IdxW'($urandom_range(0, 52));
      default:       c = IdxW'($urandom_range(1, 8));
    endcase
    wait_idle();
    write_reg(REG_POOL_SIZE, p);
    wait_idle();
    write_reg(REG_DRAW_COUNT, c);
  endtask

  // start, then words until the sample is complete or a cap is reached, with some noise
  task automatic run_sample(input int drain_at);
    int unsigned cap, sent;
    in_item_t it;
    it.kind        = KIND_START;
    it.random_word = pick_word();
    send_item(it, 1'b0, '0);
    cap = 2 * draw_goal() + 4;
    if ($urandom_range(9) == 0) cap = $urandom_range(1, draw_goal() + 1);
    sent = 0;
    while (next_slot < draw_goal() && sent < cap) begin
      if (sent == drain_at) wait_idle();
      it.kind        = ($urandom_range(39) == 0) ? KIND_START : KIND_WORD;
      it.random_word = pick_word();
      send_item(it, 1'b0, '0);
      sent++;
    end
    repeat ($urandom_range(0, 2)) begin
      it.kind        = KIND_WORD;
      it.random_word = pick_word();
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int unsigned goal;
    pool_reg  = IdxW'(52);
    count_reg = '0;
    restack();

    add_item(KIND_START, 0,            1'b1, outcome(0, 0, 0, 0, 1));
    add_item(KIND_WORD,  0,            1'b1, outcome(0, 0, 0, 0, 1));
    add_cfg(REG_DRAW_COUNT, 52);
    add_item(KIND_START, 32'h7FFFFFFF, 1'b1, outcome(0, 0, 0, 0, 0));
    add_item(KIND_WORD,  0,            1'b1, outcome(1, 0, 0, 0, 0));
    add_item(KIND_WORD,  32'h7FFFFFFF, 1'b1, outcome(0, 0, 0, 0, 0));
    add_item(KIND_WORD,  32'h7FFFFFE5, 1'b1, outcome(1, 1, 51, 0, 0));
    add_item(KIND_WORD,  32'h7FFFFFE6, 1'b1, outcome(0, 0, 0, 0, 0));
    add_item(KIND_WORD,  32'h2AAAAAAA, 1'b0, '0);
    add_cfg(REG_POOL_SIZE, 1);
    add_item(KIND_START, 32'h55555555, 1'b1, outcome(0, 0, 0, 0, 0));
    add_item(KIND_WORD,  32'h7FFFFFFF, 1'b1, outcome(0, 0, 0, 0, 0));
    add_item(KIND_WORD,  32'h7FFFFFFE, 1'b1, outcome(1, 0, 0, 1, 1));
    add_item(KIND_WORD,  32'h55555555, 1'b1, outcome(0, 0, 0, 0, 1));
    add_cfg(REG_POOL_SIZE, 2);
    add_cfg(REG_DRAW_COUNT, 2);
    add_item(KIND_START, 0,            1'b1, outcome(0, 0, 0, 0, 0));
    add_item(KIND_WORD,  32'h40000000, 1'b1, outcome(1, 0, 1, 0, 0));
    add_item(KIND_WORD,  0,            1'b1, outcome(1, 1, 0, 1, 1));
    add_cfg(REG_POOL_SIZE, 63);
    add_cfg(REG_DRAW_COUNT, 63);
    add_item(KIND_START, 0,            1'b1, outcome(0, 0, 0, 0, 0));
    add_item(KIND_WORD,  32'h7FFFFFFF, 1'b0, '0);
    add_item(KIND_WORD,  32'h12345678, 1'b0, '0);
    add_item(KIND_WORD,  32'h6DB6DB6D, 1'b0, '0);
    add_item(KIND_START, 32'h1,        1'b0, '0);
    add_cfg(REG_DRAW_COUNT, 0);
    add_cfg(REG_POOL_SIZE, 0);
    add_item(KIND_START, 0,            1'b1, outcome(0, 0, 0, 0, 1));
    add_item(KIND_WORD,  32'h7FFFFFFF, 1'b1, outcome(0, 0, 0, 0, 1));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].op == ROW_CFG) begin
        wait_idle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_item(script[i].item, script[i].typed, script[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 77 : 0;
      rx_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 18 : 0;
      goal = live_items + PHASE_ITEMS;
      reconfigure();
      // hold the output off while words keep coming, then drain mid-sample
      hold_req++;
      run_sample(3);
      while (live_items < goal) begin
        if ($urandom_range(2) == 0) reconfigure();
        run_sample(($urandom_range(19) == 0) ? int'($urandom_range(0, 5)) : -1);
      end
    end

    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_draws.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
